FILE: design/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design folder.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The condition must be true on the clock edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: design/ptda_pkg.sv
// -----------------------------------------------------------------------------
// ptda_pkg
// Types, codes and constants of the peer table with dedup and aging.
// -----------------------------------------------------------------------------
`default_nettype none

package ptda_pkg;

    localparam int SLOT_W = 6;

    // Function codes of an input item.
    localparam logic [1:0] F_PACKET = 2'd0;
    localparam logic [1:0] F_SWEEP  = 2'd1;
    localparam logic [1:0] F_QUERY  = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_ACCEPT   = 3'd0;
    localparam logic [2:0] K_DUP      = 3'd1;
    localparam logic [2:0] K_BAD_HDR  = 3'd2;
    localparam logic [2:0] K_LOW_PORT = 3'd3;
    localparam logic [2:0] K_FULL     = 3'd4;
    localparam logic [2:0] K_QUERY    = 3'd5;
    localparam logic [2:0] K_EXPIRED  = 3'd6;
    localparam logic [2:0] K_NONE_EXP = 3'd7;

    localparam logic [15:0] MIN_REPLY_PORT = 16'd1024;
    localparam logic [30:0] TIMEOUT_RESET  = 31'd120000;

    // One table entry; an address of zero marks a free entry.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] id;
        logic [31:0] heard;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic [2:0]        kind;
        logic              ack_req;
        logic [15:0]       ack_port;
        logic [31:0]       ack_msg_id;
        logic [31:0]       entry_addr;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       heard;
        logic              last;
    } t_result;

    // Builds a result with the last flag cleared.
    function automatic t_result mk_result(
        input logic [2:0]        kind,
        input logic              ack,
        input logic [15:0]       port,
        input logic [31:0]       id,
        input logic [31:0]       addr,
        input logic [SLOT_W-1:0] slot,
        input logic [31:0]       heard
    );
        t_result r;
        r.kind       = kind;
        r.ack_req    = ack;
        r.ack_port   = ack ? port : 16'd0;
        r.ack_msg_id = ack ? id : 32'd0;
        r.entry_addr = addr;
        r.slot       = slot;
        r.heard      = heard;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ptda_cell.sv
// -----------------------------------------------------------------------------
// ptda_cell
// One link of the entry ring: holds a table entry and passes it on a shift.
// -----------------------------------------------------------------------------
`default_nettype none

module ptda_cell
    import ptda_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_shift,
    input  wire t_entry i_entry,
    output t_entry      o_entry
);

    t_entry r_entry;

    // Take the neighbor's entry on every shift; reset frees the entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: design/peer_table_dedup_aging_unit.sv
// New or updated packet: busy for a lookup pass, a write pass and the done state.
// Duplicate, full table, query and sweep: busy for one pass and the done state.
// Bad header and low port: no busy time; the result comes the cycle after the transfer.
// The final result is strobed in the first idle cycle; a new transfer can be taken then.
// Sweep expiries stream during the pass, each one strobed once the next one is found.
// Synchronous active-low reset frees all entries and sets the timeout; no output stall.
// -----------------------------------------------------------------------------
// peer_table_dedup_aging_unit
// Peer table with duplicate detection and aging, built as a rotating ring of
// entry cells scanned by one controller.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module peer_table_dedup_aging_unit
    import ptda_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_peer_addr,
    input  wire logic [31:0] i_msg_id,
    input  wire logic [15:0] i_reply_port,
    input  wire logic        i_wants_ack,
    input  wire logic        i_header_ok,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata,
    output logic             o_strobe,
    output logic [2:0]       o_kind,
    output logic             o_ack_req,
    output logic [15:0]      o_ack_port,
    output logic [31:0]      o_ack_msg_id,
    output logic [31:0]      o_entry_addr,
    output logic [5:0]       o_slot,
    output logic [31:0]      o_heard_ms,
    output logic             o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] CNT_LAST = IW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Controller registers.
    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_func, n_func;
    logic [31:0]   r_addr, n_addr;
    logic [31:0]   r_id, n_id;
    logic [15:0]   r_port, n_port;
    logic          r_want, n_want;
    logic [31:0]   r_now, n_now;
    logic          r_dup_f, n_dup_f;
    logic          r_am_f, n_am_f;
    logic          r_free_f, n_free_f;
    logic [IW-1:0] r_dup_i, n_dup_i;
    logic [IW-1:0] r_am_i, n_am_i;
    logic [IW-1:0] r_free_i, n_free_i;
    logic [IW-1:0] r_tgt, n_tgt;
    t_result       r_pend, n_pend;
    logic          r_pend_vld, n_pend_vld;
    t_result       r_res, n_res;
    logic          r_out_vld, n_out_vld;
    logic [30:0]   r_timeout;

    // Ring wiring.
    t_entry        w_cell [TABLE_DEPTH];
    t_entry        w_head;
    t_entry        n_tail;
    logic          w_shift;

    // Per-cycle compare results on the head entry.
    logic          w_valid, w_am, w_dup, w_exp, w_end;
    logic [31:0]   w_age;
    logic [SLOT_W-1:0] w_cslot;

    // Ring of entry cells: cell 0 is the head, the tail takes the write-back.
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_ring
            if (g == TABLE_DEPTH - 1) begin : g_tail
                ptda_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_entry (n_tail),
                    .o_entry (w_cell[g])
                );
            end else begin : g_mid
                ptda_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_entry (w_cell[g+1]),
                    .o_entry (w_cell[g])
                );
            end
        end
    endgenerate

    assign w_head  = w_cell[0];
    assign w_shift = (r_state == S_PASS1) || (r_state == S_PASS2);

    // Compares of the entry now at the head of the ring.
    assign w_valid = (w_head.addr != 32'd0);
    assign w_am    = w_valid && (w_head.addr == r_addr);
    assign w_dup   = w_am && (w_head.id == r_id);
    assign w_age   = r_now - w_head.heard;
    assign w_exp   = w_valid && (w_age > {1'b0, r_timeout});
    assign w_end   = (r_cnt == CNT_LAST);
    assign w_cslot = SLOT_W'(r_cnt);

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // Scan controller.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_func     = r_func;
        n_addr     = r_addr;
        n_id       = r_id;
        n_port     = r_port;
        n_want     = r_want;
        n_now      = r_now;
        n_dup_f    = r_dup_f;
        n_am_f     = r_am_f;
        n_free_f   = r_free_f;
        n_dup_i    = r_dup_i;
        n_am_i     = r_am_i;
        n_free_i   = r_free_i;
        n_tgt      = r_tgt;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_res      = r_res;
        n_out_vld  = 1'b0;
        n_tail     = w_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func     = i_func;
                    n_addr     = i_peer_addr;
                    n_id       = i_msg_id;
                    n_port     = i_reply_port;
                    n_want     = i_wants_ack;
                    n_now      = i_now_ms;
                    n_cnt      = '0;
                    n_dup_f    = 1'b0;
                    n_am_f     = 1'b0;
                    n_free_f   = 1'b0;
                    n_pend_vld = 1'b0;
                    case (i_func)
                        F_PACKET: begin
                            if (!i_header_ok || (i_peer_addr == 32'd0)) begin
                                n_res = mk_result(K_BAD_HDR, 1'b0, '0, '0, i_peer_addr,
                                                  '0, '0);
                                n_res.last = 1'b1;
                                n_out_vld  = 1'b1;
                            end else if (i_reply_port < MIN_REPLY_PORT) begin
                                n_res = mk_result(K_LOW_PORT, 1'b0, '0, '0, i_peer_addr,
                                                  '0, '0);
                                n_res.last = 1'b1;
                                n_out_vld  = 1'b1;
                            end else begin
                                n_state = S_PASS1;
                            end
                        end
                        F_SWEEP: begin
                            n_state = S_PASS1;
                        end
                        F_QUERY: begin
                            n_pend = mk_result(K_QUERY, 1'b0, '0, '0, i_peer_addr,
                                               '0, '0);
                            n_pend_vld = 1'b1;
                            n_state    = S_PASS1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_PASS1: begin
                n_cnt = w_end ? '0 : r_cnt + 1'b1;
                case (r_func)
                    F_PACKET: begin
                        // First duplicate is refreshed as it passes the head.
                        if (w_dup && !r_dup_f) begin
                            n_dup_f      = 1'b1;
                            n_dup_i      = r_cnt;
                            n_tail.heard = r_now;
                        end
                        if (w_am && !r_am_f) begin
                            n_am_f = 1'b1;
                            n_am_i = r_cnt;
                        end
                        // Highest free slot wins.
                        if (!w_valid) begin
                            n_free_f = 1'b1;
                            n_free_i = r_cnt;
                        end
                        if (w_end) begin
                            n_pend_vld = 1'b1;
                            if (n_dup_f) begin
                                n_pend  = mk_result(K_DUP, r_want, r_port, r_id, r_addr,
                                                    SLOT_W'(n_dup_i), '0);
                                n_state = S_DONE;
                            end else if (n_am_f || n_free_f) begin
                                n_tgt   = n_am_f ? n_am_i : n_free_i;
                                n_pend  = mk_result(K_ACCEPT, r_want, r_port, r_id, r_addr,
                                                    SLOT_W'(n_tgt), '0);
                                n_state = S_PASS2;
                            end else begin
                                n_pend  = mk_result(K_FULL, 1'b0, '0, '0, r_addr, '0, '0);
                                n_state = S_DONE;
                            end
                        end
                    end
                    F_SWEEP: begin
                        // Each expiry pushes out the one held before it.
                        if (w_exp) begin
                            n_tail.addr  = '0;
                            n_tail.heard = '0;
                            if (r_pend_vld) begin
                                n_res     = r_pend;
                                n_out_vld = 1'b1;
                            end
                            n_pend = mk_result(K_EXPIRED, 1'b0, '0, '0, w_head.addr,
                                               w_cslot, w_head.heard);
                            n_pend_vld = 1'b1;
                        end
                        if (w_end) begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        // Query: the first active match supplies the answer.
                        if (w_am && !r_am_f) begin
                            n_am_f       = 1'b1;
                            n_pend.heard = w_head.heard;
                            n_pend.slot  = w_cslot;
                        end
                        if (w_end) begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end

            S_PASS2: begin
                n_cnt = w_end ? '0 : r_cnt + 1'b1;
                if (r_cnt == r_tgt) begin
                    n_tail.addr  = r_addr;
                    n_tail.id    = r_id;
                    n_tail.heard = r_now;
                end
                if (w_end) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                n_res = r_pend_vld ? r_pend
                                   : mk_result(K_NONE_EXP, 1'b0, '0, '0, '0, '0, '0);
                n_res.last = 1'b1;
                n_out_vld  = 1'b1;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_dup_f    <= 1'b0;
            r_am_f     <= 1'b0;
            r_free_f   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_dup_f    <= n_dup_f;
            r_am_f     <= n_am_f;
            r_free_f   <= n_free_f;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_addr   <= n_addr;
        r_id     <= n_id;
        r_port   <= n_port;
        r_want   <= n_want;
        r_now    <= n_now;
        r_dup_i  <= n_dup_i;
        r_am_i   <= n_am_i;
        r_free_i <= n_free_i;
        r_tgt    <= n_tgt;
        r_pend   <= n_pend;
        r_res    <= n_res;
    end

    // Output ports.
    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_out_vld;
    assign o_kind       = r_res.kind;
    assign o_ack_req    = r_res.ack_req;
    assign o_ack_port   = r_res.ack_port;
    assign o_ack_msg_id = r_res.ack_msg_id;
    assign o_entry_addr = r_res.entry_addr;
    assign o_slot       = r_res.slot;
    assign o_heard_ms   = r_res.heard;
    assign o_last       = r_res.last;

    // Only a sweep, in its pass or its closing cycle, may deliver a result that is not final.
    `ASSERT_IMPLY(a_nonlast_sweep, i_clk, i_rst_n, o_strobe && !o_last,
                  ((r_state == S_PASS1) || (r_state == S_DONE)) && (r_func == F_SWEEP))
    // An accepted sweep always occupies the block.
    `ASSERT_NEXT(a_sweep_busy, i_clk, i_rst_n, i_start && !o_busy && (i_func == F_SWEEP), o_busy)
    // The ring position is back at the head whenever the block is idle.
    `ASSERT_NEVER(a_ring_aligned, i_clk, i_rst_n, (r_state == S_IDLE) && (r_cnt != '0))
    // Acks are requested only for accepted or duplicate packets.
    `ASSERT_IMPLY(a_ack_kind, i_clk, i_rst_n, o_strobe && o_ack_req,
                  (o_kind == K_ACCEPT) || (o_kind == K_DUP))

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the peer table with duplicate detection and aging.
// Items go in over the start/busy handshake. A behavioral copy of the table
// predicts every result strobe. Directed tests cover rejects, duplicates,
// queries, aging and a full table. Random traffic then runs under three
// timeout settings with different sender idling.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import ptda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 32;
    localparam int ADDR_POOL    = 40;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    // The function code that the block ignores.
    localparam logic [1:0] F_UNUSED = 2'd3;

    // One input item as it is presented on the ports.
    typedef struct {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [31:0] id;
        logic [15:0] port;
        logic        want;
        logic        hok;
        logic [31:0] now;
    } t_peer_msg;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_start      = 1'b0;
    logic [1:0]  i_func       = F_PACKET;
    logic [31:0] i_peer_addr  = '0;
    logic [31:0] i_msg_id     = '0;
    logic [15:0] i_reply_port = '0;
    logic        i_wants_ack  = 1'b0;
    logic        i_header_ok  = 1'b0;
    logic [31:0] i_now_ms     = '0;
    logic        i_cfg_we     = 1'b0;
    logic [30:0] i_cfg_wdata  = '0;
    logic        o_busy;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic        o_ack_req;
    logic [15:0] o_ack_port;
    logic [31:0] o_ack_msg_id;
    logic [31:0] o_entry_addr;
    logic [5:0]  o_slot;
    logic [31:0] o_heard_ms;
    logic        o_last;

    // Predicted copy of the table and its timeout register.
    logic [31:0] ent_addr   [TABLE_DEPTH];
    logic [31:0] ent_msg_id [TABLE_DEPTH];
    logic [31:0] ent_heard  [TABLE_DEPTH];
    logic [30:0] timeout_cfg;

    t_result     awaited_results [$];
    logic [31:0] addr_pool [ADDR_POOL];
    logic [31:0] wall_ms = 32'd1000;
    int          send_idle_pct = 17;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    peer_table_dedup_aging_unit #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (.*);

    // Free-running clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out the results of one accepted item and updates the table copy.
    task automatic update_peer_table(input t_peer_msg m);
        t_result     r;
        int          hit;
        int          spot;
        int          n_exp;
        int          n_out;
        logic [31:0] age;
        r = '0;
        r.entry_addr = m.addr;
        r.last = 1'b1;
        hit = -1;
        spot = -1;
        case (m.func)
            F_PACKET: begin
                if (!m.hok || m.addr == 32'd0) begin
                    r.kind = K_BAD_HDR;
                end else if (m.port < MIN_REPLY_PORT) begin
                    r.kind = K_LOW_PORT;
                end else begin
                    // A live entry with the same address and id makes a duplicate.
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (hit < 0 && ent_addr[i] != 32'd0 && ent_addr[i] == m.addr &&
                                ent_msg_id[i] == m.id)
                            hit = i;
                    end
                    if (hit >= 0) begin
                        ent_heard[hit] = m.now;
                        r.kind = K_DUP;
                        r.slot = hit[5:0];
                    end else begin
                        // The peer's own entry wins, else the highest free slot.
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (hit < 0 && ent_addr[i] == m.addr)
                                hit = i;
                            if (ent_addr[i] == 32'd0)
                                spot = i;
                        end
                        if (hit < 0)
                            hit = spot;
                        if (hit < 0) begin
                            r.kind = K_FULL;
                        end else begin
                            ent_addr[hit]   = m.addr;
                            ent_msg_id[hit] = m.id;
                            ent_heard[hit]  = m.now;
                            r.kind = K_ACCEPT;
                            r.slot = hit[5:0];
                        end
                    end
                    if (r.kind != K_FULL) begin
                        r.ack_req = m.want;
                        if (m.want) begin
                            r.ack_port   = m.port;
                            r.ack_msg_id = m.id;
                        end
                    end
                end
                awaited_results.push_back(r);
            end
            F_SWEEP: begin
                // Count the expiring entries first so the final one carries last.
                n_exp = 0;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    age = m.now - ent_heard[i];
                    if (ent_addr[i] != 32'd0 && age > {1'b0, timeout_cfg})
                        n_exp++;
                end
                if (n_exp == 0) begin
                    r.kind = K_NONE_EXP;
                    r.entry_addr = 32'd0;
                    awaited_results.push_back(r);
                end else begin
                    n_out = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        age = m.now - ent_heard[i];
                        if (ent_addr[i] != 32'd0 && age > {1'b0, timeout_cfg}) begin
                            n_out++;
                            r = '0;
                            r.kind = K_EXPIRED;
                            r.entry_addr = ent_addr[i];
                            r.slot = i[5:0];
                            r.heard = ent_heard[i];
                            r.last = (n_out == n_exp);
                            awaited_results.push_back(r);
                            ent_addr[i]  = 32'd0;
                            ent_heard[i] = 32'd0;
                        end
                    end
                end
            end
            F_QUERY: begin
                // A free entry never answers, so address zero is never found.
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (hit < 0 && ent_addr[i] != 32'd0 && ent_addr[i] == m.addr)
                        hit = i;
                end
                r.kind = K_QUERY;
                if (hit >= 0) begin
                    r.slot  = hit[5:0];
                    r.heard = ent_heard[hit];
                end
                awaited_results.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_peer_msg make_msg(input logic [1:0] func, input logic [31:0] addr,
                                           input logic [31:0] id, input logic [15:0] port,
                                           input logic want, input logic hok,
                                           input logic [31:0] now);
        t_peer_msg m;
        m.func = func;
        m.addr = addr;
        m.id   = id;
        m.port = port;
        m.want = want;
        m.hok  = hok;
        m.now  = now;
        return m;
    endfunction

    // Presents one item until its transfer; start drops in randomly chosen idle cycles.
    task automatic send_item(input t_peer_msg m);
        logic idle;
        logic taken;
        i_func       <= m.func;
        i_peer_addr  <= m.addr;
        i_msg_id     <= m.id;
        i_reply_port <= m.port;
        i_wants_ack  <= m.want;
        i_header_ok  <= m.hok;
        i_now_ms     <= m.now;
        taken = 1'b0;
        while (!taken) begin
            idle = ($urandom_range(99) < send_idle_pct);
            i_start <= !idle;
            @(posedge i_clk);
            taken = !idle && !o_busy;
        end
        update_peer_table(m);
    endtask

    // Lets every awaited result arrive, then gives a silent item time to finish.
    task automatic wait_drain();
        i_start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the timeout register; only called while the block is idle.
    task automatic set_timeout(input logic [30:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_cfg = value;
    endtask

    task automatic flag_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected kind=%0d ack=%0b port=%0d id=%h addr=%h slot=%0d",
                     $realtime, what, want.kind, want.ack_req, want.ack_port,
                     want.ack_msg_id, want.entry_addr, want.slot);
            $display("    expected heard=%h last=%0b, got kind=%0d ack=%0b port=%0d id=%h",
                     want.heard, want.last, got.kind, got.ack_req, got.ack_port,
                     got.ack_msg_id);
            $display("    got addr=%h slot=%0d heard=%h last=%0b",
                     got.entry_addr, got.slot, got.heard, got.last);
        end
    endtask

    // Every strobe is one result transfer; it must match the oldest awaited result.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_strobe) begin
            got.kind       = o_kind;
            got.ack_req    = o_ack_req;
            got.ack_port   = o_ack_port;
            got.ack_msg_id = o_ack_msg_id;
            got.entry_addr = o_entry_addr;
            got.slot       = o_slot;
            got.heard      = o_heard_ms;
            got.last       = o_last;
            if (awaited_results.size() == 0) begin
                want = '0;
                flag_mismatch("unexpected result", want, got);
            end else begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.ack_req !== want.ack_req ||
                        got.ack_port !== want.ack_port || got.ack_msg_id !== want.ack_msg_id ||
                        got.entry_addr !== want.entry_addr || got.slot !== want.slot ||
                        got.heard !== want.heard || got.last !== want.last)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Header failure, address zero, ports around the limit and the ignored code.
    task automatic test_rejects();
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd1, 16'd5000, 1'b1, 1'b0, wall_ms));
        send_item(make_msg(F_PACKET, 32'd0, 32'd2, 16'd5000, 1'b1, 1'b1, wall_ms));
        send_item(make_msg(F_PACKET, 32'h0A00_0002, 32'd3, 16'd1023, 1'b1, 1'b1, wall_ms));
        send_item(make_msg(F_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1,
                           32'hFFFF_FFFF));
        send_item(make_msg(F_UNUSED, 32'h0A00_0003, 32'd4, 16'd2000, 1'b1, 1'b1, wall_ms));
    endtask

    // New peers take the highest free slots; repeats refresh and report duplicates.
    task automatic test_accept_and_duplicate();
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd7, 16'd1024, 1'b1, 1'b1, 32'd1000));
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd7, 16'd1024, 1'b1, 1'b1, 32'd2000));
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd7, 16'd4000, 1'b0, 1'b1, 32'd2100));
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd8, 16'd65535, 1'b1, 1'b1, 32'd2200));
        send_item(make_msg(F_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65535, 1'b1, 1'b1,
                           32'd2300));
        send_item(make_msg(F_PACKET, 32'h0000_0001, 32'd0, 16'd30000, 1'b0, 1'b1, 32'd2400));
    endtask

    // Known peer, unknown peer and address zero.
    task automatic test_query();
        send_item(make_msg(F_QUERY, 32'h0A00_0001, 32'd0, 16'd0, 1'b0, 1'b1, 32'd2500));
        send_item(make_msg(F_QUERY, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0, 1'b0, 32'd2500));
        send_item(make_msg(F_QUERY, 32'h0BAD_0001, 32'd0, 16'd0, 1'b0, 1'b1, 32'd2500));
        send_item(make_msg(F_QUERY, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd2500));
    endtask

    // Aging at the reset timeout, with wrapping time, a zero timeout and the maximum.
    task automatic test_sweep_aging();
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd3000));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd122250));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd0));
        wait_drain();
        set_timeout(31'd0);
        send_item(make_msg(F_PACKET, 32'h0A00_0001, 32'd9, 16'd1500, 1'b1, 1'b1, 32'd5000));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd5000));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'd5001));
        wait_drain();
        set_timeout(31'h7FFF_FFFF);
        send_item(make_msg(F_PACKET, 32'h0A00_0002, 32'd9, 16'd1500, 1'b1, 1'b1, 32'd10));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'h8000_0009));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, 32'h8000_000A));
    endtask

    // Fills the table past its depth, then ages out every entry in one sweep.
    task automatic test_fill_table();
        wall_ms = 32'd100000;
        wait_drain();
        set_timeout(31'd1);
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, wall_ms));
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            send_item(make_msg(F_PACKET, $urandom_range(32'hFFFF_FFFF, 1), $urandom,
                               16'($urandom_range(65535, 1024)), 1'($urandom_range(1)),
                               1'b1, wall_ms + k));
        send_item(make_msg(F_QUERY, addr_pool[0], 32'd0, 16'd0, 1'b0, 1'b1, wall_ms));
        send_item(make_msg(F_SWEEP, 32'd0, 32'd0, 16'd0, 1'b0, 1'b1, wall_ms + 200));
    endtask

    // Random traffic over a pool of peers; mostly well-formed packets.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input logic [30:0] tmo, input int step_max);
        t_peer_msg m;
        int        done_items;
        int        pick;
        wait_drain();
        set_timeout(tmo);
        send_idle_pct = idle_pct;
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(99);
            if (pick < 68)
                m.func = F_PACKET;
            else if (pick < 82)
                m.func = F_QUERY;
            else if (pick < 96)
                m.func = F_SWEEP;
            else
                m.func = F_UNUSED;
            if ($urandom_range(99) < 88)
                m.addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
            else
                m.addr = $urandom;
            if ($urandom_range(99) < 2)
                m.addr = 32'd0;
            // A small id set makes duplicates common.
            if ($urandom_range(99) < 60)
                m.id = $urandom_range(3);
            else
                m.id = $urandom;
            if ($urandom_range(99) < 8)
                m.port = 16'($urandom_range(1023));
            else
                m.port = 16'($urandom_range(65535, 1024));
            m.want = 1'($urandom_range(1));
            m.hok  = ($urandom_range(99) < 95);
            // Time mostly creeps forward, sometimes jumps and wraps, rarely goes stale.
            if ($urandom_range(99) < 5)
                wall_ms += $urandom;
            else
                wall_ms += $urandom_range(step_max);
            if ($urandom_range(99) < 3)
                m.now = $urandom;
            else
                m.now = wall_ms;
            send_item(m);
            if (m.func != F_UNUSED)
                done_items++;
        end
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ent_addr[i]   = '0;
            ent_msg_id[i] = '0;
            ent_heard[i]  = '0;
        end
        timeout_cfg = TIMEOUT_RESET;
        for (int k = 0; k < ADDR_POOL; k++)
            addr_pool[k] = $urandom_range(32'hFFFF_FFFF, 1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rejects();
        test_accept_and_duplicate();
        test_query();
        test_sweep_aging();
        test_fill_table();
        test_random_traffic(60, 17, 31'd5000, 1000);
        test_random_traffic(60, 77, 31'd1, 3);
        test_random_traffic(60, 0, 31'($urandom_range(31'h7FFF_FFFF, 31'h0010_0000)), 1000);

        wait_drain();
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
